// File: hdl/video_test_pattern_generator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the video test pattern generator
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VTPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vtpg_pkg.sv
// ----------------------------------------------------------------------------
// vtpg_pkg
// Types, constants and tables of the video test pattern generator.
// ----------------------------------------------------------------------------
package vtpg_pkg;

  localparam int SCREEN_W = 960;
  localparam int SCREEN_H = 544;

  localparam int COORD_W = 10;
  localparam int FRAME_W = 24;
  localparam int SEL_W   = 5;
  localparam int SPEED_W = 4;
  localparam int CH_W    = 8;
  localparam int CH_MAX  = 2**CH_W - 1;

  localparam int MOT_W = FRAME_W + SPEED_W;
  localparam int DIV_W = MOT_W;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_SPEED   = 1'b1;

  localparam logic [SEL_W-1:0]   PATTERN_RESET = '0;
  localparam logic [SPEED_W-1:0] SPEED_RESET   = SPEED_W'(2);

  localparam int BAR_SPAN      = 64;
  localparam int GRAY_STEPS    = 16;
  localparam int INVERT_PERIOD = 60;
  localparam int HUE_SPAN      = 360;
  localparam int HUE_SECTOR    = 60;
  localparam int NUM_BARS      = 8;
  localparam int NUM_SOLID     = 8;
  localparam int CHECK_FINE    = 3;
  localparam int CHECK_COARSE  = 6;

  localparam int COORD_MAX = 2**COORD_W - 1;
  localparam int HSPAN     = SCREEN_W + BAR_SPAN;
  localparam int VSPAN     = SCREEN_H + BAR_SPAN;
  localparam int BAR_H     = SCREEN_H / NUM_BARS;
  localparam int BAR_W     = SCREEN_W / NUM_BARS;
  localparam int GRAY_W    = SCREEN_W / GRAY_STEPS;
  localparam int GRAY_INC  = CH_MAX / (GRAY_STEPS - 1);
  localparam int MIN_SIDE  = (SCREEN_W < SCREEN_H) ? SCREEN_W : SCREEN_H;
  localparam int MAX_SPAN  = (HSPAN > VSPAN) ? HSPAN : VSPAN;

  localparam int RAMP_W     = $clog2((COORD_MAX * CH_MAX) / MIN_SIDE + 1);
  localparam int STEP_W     = $clog2(COORD_MAX / GRAY_W + 1);
  localparam int STEP_IDX_W = $clog2(GRAY_STEPS);
  localparam int POS_W      = $clog2(MAX_SPAN);
  localparam int CMP_W      = ((POS_W > COORD_W) ? POS_W : COORD_W) + 1;
  localparam int HUE_W      = $clog2(HUE_SPAN);
  localparam int HREM_W     = $clog2(HUE_SECTOR + 1);
  localparam int SECT_W     = $clog2(HUE_SPAN / HUE_SECTOR);
  localparam int BAR_IDX_W  = $clog2(NUM_BARS);

  // Divisors and their reciprocals scaled by 2**DIV_W. The estimated
  // quotient is low by at most one, which the divider corrects.
  localparam logic [DIV_W-1:0] DV_HUE  = DIV_W'(HUE_SPAN);
  localparam logic [DIV_W-1:0] DV_HBAR = DIV_W'(HSPAN);
  localparam logic [DIV_W-1:0] DV_VBAR = DIV_W'(VSPAN);
  localparam logic [DIV_W-1:0] DV_RX   = DIV_W'(SCREEN_W);
  localparam logic [DIV_W-1:0] DV_RY   = DIV_W'(SCREEN_H);
  localparam logic [DIV_W-1:0] DV_BARH = DIV_W'(BAR_H);
  localparam logic [DIV_W-1:0] DV_BARV = DIV_W'(BAR_W);
  localparam logic [DIV_W-1:0] DV_GRAY = DIV_W'(GRAY_W);
  localparam logic [DIV_W-1:0] DV_INV  = DIV_W'(INVERT_PERIOD);

  localparam logic [DIV_W-1:0] RC_HUE  = DIV_W'((64'd1 << DIV_W) / HUE_SPAN);
  localparam logic [DIV_W-1:0] RC_HBAR = DIV_W'((64'd1 << DIV_W) / HSPAN);
  localparam logic [DIV_W-1:0] RC_VBAR = DIV_W'((64'd1 << DIV_W) / VSPAN);
  localparam logic [DIV_W-1:0] RC_RX   = DIV_W'((64'd1 << DIV_W) / SCREEN_W);
  localparam logic [DIV_W-1:0] RC_RY   = DIV_W'((64'd1 << DIV_W) / SCREEN_H);
  localparam logic [DIV_W-1:0] RC_BARH = DIV_W'((64'd1 << DIV_W) / BAR_H);
  localparam logic [DIV_W-1:0] RC_BARV = DIV_W'((64'd1 << DIV_W) / BAR_W);
  localparam logic [DIV_W-1:0] RC_GRAY = DIV_W'((64'd1 << DIV_W) / GRAY_W);
  localparam logic [DIV_W-1:0] RC_INV  = DIV_W'((64'd1 << DIV_W) / INVERT_PERIOD);

  localparam logic [SEL_W-1:0] PAT_HGRAD    = SEL_W'(8);
  localparam logic [SEL_W-1:0] PAT_VGRAD    = SEL_W'(9);
  localparam logic [SEL_W-1:0] PAT_CHECK8   = SEL_W'(10);
  localparam logic [SEL_W-1:0] PAT_CHECK64  = SEL_W'(11);
  localparam logic [SEL_W-1:0] PAT_HBARS    = SEL_W'(12);
  localparam logic [SEL_W-1:0] PAT_VBARS    = SEL_W'(13);
  localparam logic [SEL_W-1:0] PAT_MOVE_H   = SEL_W'(14);
  localparam logic [SEL_W-1:0] PAT_MOVE_V   = SEL_W'(15);
  localparam logic [SEL_W-1:0] PAT_HUE      = SEL_W'(16);
  localparam logic [SEL_W-1:0] PAT_INVERT   = SEL_W'(17);
  localparam logic [SEL_W-1:0] PAT_GRAYSTEP = SEL_W'(18);

  typedef logic [CH_W-1:0] vtpg_chan_t;

  typedef struct packed {
    vtpg_chan_t r;
    vtpg_chan_t g;
    vtpg_chan_t b;
  } vtpg_rgb_t;

  typedef struct packed {
    logic [SEL_W-1:0]   pattern;
    logic [SPEED_W-1:0] speed;
  } vtpg_cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } vtpg_div_t;

  // Per-pixel operands once all divisions are done.
  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [HUE_W-1:0]     hue;
    logic [POS_W-1:0]     hpos;
    logic [POS_W-1:0]     vpos;
    logic [RAMP_W-1:0]    ramp_x;
    logic [RAMP_W-1:0]    ramp_y;
    logic [BAR_IDX_W-1:0] bar_h;
    logic [BAR_IDX_W-1:0] bar_v;
    logic [STEP_W-1:0]    step;
    logic                 invert;
  } vtpg_pix_t;

  typedef vtpg_chan_t vtpg_ramp_t [HUE_SECTOR+1];

  localparam vtpg_rgb_t SOLID_RGB [NUM_SOLID] = '{
    '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
    '{8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'hFF},
    '{8'hFF, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00}
  };

  localparam vtpg_rgb_t BAR_RGB [NUM_BARS] = '{
    '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
    '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF}, '{8'hFF, 8'hFF, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00}
  };

  // Entry i is floor(255 * i / 60); the falling edge reads entry 60 - i.
  function automatic vtpg_ramp_t make_hue_ramp();
    vtpg_ramp_t tbl;
    for (int i = 0; i <= HUE_SECTOR; i++) begin
      tbl[i] = CH_W'((CH_MAX * i) / HUE_SECTOR);
    end
    return tbl;
  endfunction

  localparam vtpg_ramp_t HUE_RAMP = make_hue_ramp();

  function automatic vtpg_rgb_t to_gray(input vtpg_chan_t lvl);
    vtpg_rgb_t c;
    c.r = lvl;
    c.g = lvl;
    c.b = lvl;
    return c;
  endfunction

endpackage

// File: hdl/vtpg_cdiv.sv
// ----------------------------------------------------------------------------
// vtpg_cdiv
// Three-stage divider by a constant: reciprocal multiply, quotient back
// multiply and subtract, then a single correction step.
// ----------------------------------------------------------------------------
module vtpg_cdiv (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [vtpg_pkg::DIV_W-1:0] dividend_i,
  input  logic [vtpg_pkg::DIV_W-1:0] divisor_i,
  input  logic [vtpg_pkg::DIV_W-1:0] recip_i,
  output vtpg_pkg::vtpg_div_t        res_o
);
  import vtpg_pkg::*;

  logic [2*DIV_W-1:0] prod_d, prod_q;
  logic [DIV_W-1:0]   num_q;
  logic [DIV_W-1:0]   qest_d, qest_q;
  logic [DIV_W-1:0]   rraw_d, rraw_q;
  vtpg_div_t          res_d, res_q;

  assign prod_d = {{DIV_W{1'b0}}, dividend_i} * {{DIV_W{1'b0}}, recip_i};

  // The estimate is never above the true quotient and at most one below it,
  // so the raw remainder lies below twice the divisor.
  assign qest_d = prod_q[2*DIV_W-1:DIV_W];
  assign rraw_d = num_q - qest_d * divisor_i;

  always_comb begin
    if (rraw_q >= divisor_i) begin
      res_d.quot = qest_q + DIV_W'(1);
      res_d.rem  = rraw_q - divisor_i;
    end else begin
      res_d.quot = qest_q;
      res_d.rem  = rraw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      num_q  <= dividend_i;
      qest_q <= qest_d;
      rraw_q <= rraw_d;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: hdl/vtpg_cfg.sv
// ----------------------------------------------------------------------------
// vtpg_cfg
// APB register file holding the pattern select and animation speed.
// ----------------------------------------------------------------------------
module vtpg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vtpg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vtpg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vtpg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output vtpg_pkg::vtpg_cfg_t             cfg_o
);
  import vtpg_pkg::*;

  logic               wr_en;
  logic [SEL_W-1:0]   pattern_d, pattern_q;
  logic [SPEED_W-1:0] speed_d, speed_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    pattern_d = pattern_q;
    speed_d   = speed_q;
    if (wr_en) begin
      case (paddr[REG_SEL_BIT])
        REG_PATTERN: pattern_d = pwdata[SEL_W-1:0];
        REG_SPEED:   speed_d   = pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_PATTERN: prdata = APB_DATA_W'(pattern_q);
      REG_SPEED:   prdata = APB_DATA_W'(speed_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PATTERN_RESET;
      speed_q   <= SPEED_RESET;
    end else begin
      pattern_q <= pattern_d;
      speed_q   <= speed_d;
    end
  end

  assign cfg_o.pattern = pattern_q;
  assign cfg_o.speed   = speed_q;

endmodule

// File: hdl/vtpg_color.sv
// ----------------------------------------------------------------------------
// vtpg_color
// Two-stage color mapper: pattern selection and hue sector split, then the
// hue ramp lookup and the output register.
// ----------------------------------------------------------------------------
module vtpg_color (
  input  logic                clk_i,
  input  logic                en_i,
  input  vtpg_pkg::vtpg_cfg_t cfg_i,
  input  vtpg_pkg::vtpg_pix_t pix_i,
  output vtpg_pkg::vtpg_rgb_t rgb_o
);
  import vtpg_pkg::*;

  vtpg_chan_t             rx_lvl, ry_lvl, step_lvl;
  logic [STEP_IDX_W-1:0]  step_idx;
  logic [CMP_W-1:0]       xe, ye, hpe, vpe;
  logic                   in_hbar, in_vbar;
  logic [HUE_W-1:0]       hue_base;
  logic [SECT_W-1:0]      sector_d, sector_q;
  logic [HREM_W-1:0]      hrem_d, hrem_q;
  logic                   is_hue_d, is_hue_q;
  vtpg_rgb_t              base_d, base_q;
  vtpg_rgb_t              rgb_d, rgb_q;
  vtpg_chan_t             t_up, t_down;

  // Gradients saturate for coordinates past the screen edge.
  assign rx_lvl = (pix_i.ramp_x > RAMP_W'(CH_MAX)) ? '1 : CH_W'(pix_i.ramp_x);
  assign ry_lvl = (pix_i.ramp_y > RAMP_W'(CH_MAX)) ? '1 : CH_W'(pix_i.ramp_y);

  assign step_idx = (pix_i.step > STEP_W'(GRAY_STEPS - 1)) ?
                    STEP_IDX_W'(GRAY_STEPS - 1) : STEP_IDX_W'(pix_i.step);
  assign step_lvl = CH_W'(step_idx * GRAY_INC);

  assign xe  = CMP_W'(pix_i.x);
  assign ye  = CMP_W'(pix_i.y);
  assign hpe = CMP_W'(pix_i.hpos);
  assign vpe = CMP_W'(pix_i.vpos);

  assign in_hbar = (xe + CMP_W'(BAR_SPAN) >= hpe) && (xe < hpe);
  assign in_vbar = (ye + CMP_W'(BAR_SPAN) >= vpe) && (ye < vpe);

  always_comb begin
    sector_d = '0;
    for (int s = 1; s < HUE_SPAN / HUE_SECTOR; s++) begin
      if (pix_i.hue >= HUE_W'(s * HUE_SECTOR)) begin
        sector_d = SECT_W'(s);
      end
    end
    hue_base = HUE_W'(sector_d * HUE_SECTOR);
    hrem_d   = HREM_W'(pix_i.hue - hue_base);
  end

  always_comb begin
    base_d   = '0;
    is_hue_d = 1'b0;
    if (cfg_i.pattern < SEL_W'(NUM_SOLID)) begin
      base_d = SOLID_RGB[cfg_i.pattern[BAR_IDX_W-1:0]];
    end else begin
      case (cfg_i.pattern)
        PAT_HGRAD:    base_d = to_gray(rx_lvl);
        PAT_VGRAD:    base_d = to_gray(ry_lvl);
        PAT_CHECK8:   base_d = to_gray({CH_W{pix_i.x[CHECK_FINE] ^ pix_i.y[CHECK_FINE]}});
        PAT_CHECK64:  base_d = to_gray({CH_W{pix_i.x[CHECK_COARSE] ^
                                             pix_i.y[CHECK_COARSE]}});
        PAT_HBARS:    base_d = BAR_RGB[pix_i.bar_h];
        PAT_VBARS:    base_d = BAR_RGB[pix_i.bar_v];
        PAT_MOVE_H:   base_d = to_gray({CH_W{in_hbar}});
        PAT_MOVE_V:   base_d = to_gray({CH_W{in_vbar}});
        PAT_HUE:      is_hue_d = 1'b1;
        PAT_INVERT:   base_d = to_gray({CH_W{pix_i.invert}});
        PAT_GRAYSTEP: base_d = to_gray(step_lvl);
        default:      base_d = '0;
      endcase
    end
  end

  assign t_up   = HUE_RAMP[hrem_q];
  assign t_down = HUE_RAMP[HREM_W'(HUE_SECTOR) - hrem_q];

  always_comb begin
    rgb_d = base_q;
    if (is_hue_q) begin
      case (sector_q)
        3'd0:    rgb_d = '{8'hFF, t_up, 8'h00};
        3'd1:    rgb_d = '{t_down, 8'hFF, 8'h00};
        3'd2:    rgb_d = '{8'h00, 8'hFF, t_up};
        3'd3:    rgb_d = '{8'h00, t_down, 8'hFF};
        3'd4:    rgb_d = '{t_up, 8'h00, 8'hFF};
        default: rgb_d = '{8'hFF, 8'h00, t_down};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q   <= base_d;
      is_hue_q <= is_hue_d;
      sector_q <= sector_d;
      hrem_q   <= hrem_d;
      rgb_q    <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

// File: hdl/video_test_pattern_generator.sv
// ----------------------------------------------------------------------------
// video_test_pattern_generator: per-pixel test pattern source, 6-stage pipeline
// One pixel per cycle while the output is not stalled.
// Throughput is set by the pipeline: a held output stalls every stage at once.
// Reset clears the valid bits and loads pattern 0 and speed 2; no clear pass.
// ----------------------------------------------------------------------------
`include "video_test_pattern_generator_defines.svh"

module video_test_pattern_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [vtpg_pkg::COORD_W-1:0]    pixel_x_i,
  input  logic [vtpg_pkg::COORD_W-1:0]    pixel_y_i,
  input  logic [vtpg_pkg::FRAME_W-1:0]    frame_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [vtpg_pkg::CH_W-1:0]       red_o,
  output logic [vtpg_pkg::CH_W-1:0]       green_o,
  output logic [vtpg_pkg::CH_W-1:0]       blue_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vtpg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vtpg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vtpg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import vtpg_pkg::*;

  localparam int DIV_LAT = 3;
  localparam int PIPE_D  = DIV_LAT + 3;

  vtpg_cfg_t          cfg;
  logic               en;
  logic [PIPE_D-1:0]  vld_q;

  logic [COORD_W-1:0] x1_q, y1_q;
  logic [FRAME_W-1:0] frame1_q;
  logic [MOT_W-1:0]   mot_d, mot1_q;
  logic [DIV_W-1:0]   xs_d, xs1_q, ys_d, ys1_q;
  logic [COORD_W-1:0] x_dly_q [DIV_LAT];
  logic [COORD_W-1:0] y_dly_q [DIV_LAT];

  vtpg_div_t div_hue, div_hbar, div_vbar, div_rx, div_ry;
  vtpg_div_t div_barh, div_barv, div_gray, div_inv;
  vtpg_pix_t pix;
  vtpg_rgb_t rgb;

  logic      motion_rem_ok, coord_rem_ok;

  // The whole pipeline holds while a finished result waits downstream.
  assign in_stall_o  = vld_q[PIPE_D-1] & out_stall_i;
  assign en          = ~in_stall_o;
  assign out_valid_o = vld_q[PIPE_D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_D-2:0], in_valid_i};
    end
  end

  assign mot_d = MOT_W'(frame_number_i) * MOT_W'(cfg.speed);
  assign xs_d  = DIV_W'(pixel_x_i) * DIV_W'(CH_MAX);
  assign ys_d  = DIV_W'(pixel_y_i) * DIV_W'(CH_MAX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q       <= pixel_x_i;
      y1_q       <= pixel_y_i;
      frame1_q   <= frame_number_i;
      mot1_q     <= mot_d;
      xs1_q      <= xs_d;
      ys1_q      <= ys_d;
      x_dly_q[0] <= x1_q;
      y_dly_q[0] <= y1_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        x_dly_q[i] <= x_dly_q[i-1];
        y_dly_q[i] <= y_dly_q[i-1];
      end
    end
  end

  vtpg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vtpg_cdiv u_div_hue (
    .clk_i(clk_i), .en_i(en), .dividend_i(mot1_q),
    .divisor_i(DV_HUE), .recip_i(RC_HUE), .res_o(div_hue)
  );

  vtpg_cdiv u_div_hbar (
    .clk_i(clk_i), .en_i(en), .dividend_i(mot1_q),
    .divisor_i(DV_HBAR), .recip_i(RC_HBAR), .res_o(div_hbar)
  );

  vtpg_cdiv u_div_vbar (
    .clk_i(clk_i), .en_i(en), .dividend_i(mot1_q),
    .divisor_i(DV_VBAR), .recip_i(RC_VBAR), .res_o(div_vbar)
  );

  vtpg_cdiv u_div_rx (
    .clk_i(clk_i), .en_i(en), .dividend_i(xs1_q),
    .divisor_i(DV_RX), .recip_i(RC_RX), .res_o(div_rx)
  );

  vtpg_cdiv u_div_ry (
    .clk_i(clk_i), .en_i(en), .dividend_i(ys1_q),
    .divisor_i(DV_RY), .recip_i(RC_RY), .res_o(div_ry)
  );

  vtpg_cdiv u_div_barh (
    .clk_i(clk_i), .en_i(en), .dividend_i(DIV_W'(y1_q)),
    .divisor_i(DV_BARH), .recip_i(RC_BARH), .res_o(div_barh)
  );

  vtpg_cdiv u_div_barv (
    .clk_i(clk_i), .en_i(en), .dividend_i(DIV_W'(x1_q)),
    .divisor_i(DV_BARV), .recip_i(RC_BARV), .res_o(div_barv)
  );

  vtpg_cdiv u_div_gray (
    .clk_i(clk_i), .en_i(en), .dividend_i(DIV_W'(x1_q)),
    .divisor_i(DV_GRAY), .recip_i(RC_GRAY), .res_o(div_gray)
  );

  vtpg_cdiv u_div_inv (
    .clk_i(clk_i), .en_i(en), .dividend_i(DIV_W'(frame1_q)),
    .divisor_i(DV_INV), .recip_i(RC_INV), .res_o(div_inv)
  );

  assign pix.x      = x_dly_q[DIV_LAT-1];
  assign pix.y      = y_dly_q[DIV_LAT-1];
  assign pix.hue    = HUE_W'(div_hue.rem);
  assign pix.hpos   = POS_W'(div_hbar.rem);
  assign pix.vpos   = POS_W'(div_vbar.rem);
  assign pix.ramp_x = RAMP_W'(div_rx.quot);
  assign pix.ramp_y = RAMP_W'(div_ry.quot);
  assign pix.bar_h  = div_barh.quot[BAR_IDX_W-1:0];
  assign pix.bar_v  = div_barv.quot[BAR_IDX_W-1:0];
  assign pix.step   = STEP_W'(div_gray.quot);
  assign pix.invert = div_inv.quot[0];

  vtpg_color u_color (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg),
    .pix_i (pix),
    .rgb_o (rgb)
  );

  assign red_o   = rgb.r;
  assign green_o = rgb.g;
  assign blue_o  = rgb.b;

  assign motion_rem_ok = (div_hue.rem < DV_HUE) && (div_hbar.rem < DV_HBAR) &&
                         (div_vbar.rem < DV_VBAR);
  assign coord_rem_ok  = (div_rx.rem < DV_RX) && (div_barh.rem < DV_BARH) &&
                         (div_gray.rem < DV_GRAY) && (div_inv.rem < DV_INV);

  `VTPG_ASSERT_IMP(a_motion_rem, vld_q[DIV_LAT], motion_rem_ok, "motion remainder out of range")
  `VTPG_ASSERT_IMP(a_coord_rem, vld_q[DIV_LAT], coord_rem_ok, "coordinate remainder out of range")
  `VTPG_ASSERT_NXT(a_stall_keeps, in_stall_o, out_valid_o, "held result lost during stall")
  `VTPG_ASSERT_IMP(a_stall_cause, !out_valid_o, !in_stall_o, "input stalled with empty output")

endmodule
